@@ sv/csws_pkg.sv @@
package csws_pkg;

  localparam int unsigned MAX_RES = 4;
  localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_RES);

  localparam logic [7:0] CH_NUL     = 8'h00;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] PRINT_LO   = 8'd32;
  localparam logic [7:0] PRINT_HI   = 8'd127;

  // filter state of both passes
  typedef struct packed {
    logic [7:0] p1_held;
    logic       p1_full;
    logic       in_line;
    logic [7:0] p2_held;
    logic       p2_full;
    logic       in_block;
    logic [7:0] prior;
  } filt_st_t;

  // one byte pushed through a pass: new state and possibly one kept byte
  typedef struct packed {
    filt_st_t   st;
    logic       keep;
    logic [7:0] ch;
  } feed_t;

  // results of one input word, handed to the output buffer
  typedef struct packed {
    logic                     load;
    logic [MAX_RES-1:0][7:0]  bytes;
    logic [CNT_W-1:0]         cnt;
    logic                     has;
    logic                     eot;
  } batch_t;

  function automatic feed_t feed_pass2(filt_st_t s, logic [7:0] nxt);
    feed_t      r;
    logic [7:0] c0;
    logic [7:0] c1;
    r    = '0;
    r.st = s;
    c0   = s.p2_held;
    c1   = nxt;
    if (!s.p2_full) begin
      r.st.p2_held = nxt;
      r.st.p2_full = 1'b1;
    end else begin
      if (c0 == CH_SLASH && c1 == CH_STAR) begin
        r.st.in_block = 1'b1;
        c0 = CH_SPACE;
        c1 = CH_SPACE;
      end else if (c0 == CH_STAR && c1 == CH_SLASH) begin
        r.st.in_block = 1'b0;
        c0 = CH_SPACE;
        c1 = CH_SPACE;
      end
      r.keep = !r.st.in_block && !(c0 == CH_SPACE && c1 == CH_SPACE) &&
               !(s.prior == CH_STAR && c0 == CH_SPACE);
      r.ch         = c0;
      r.st.prior   = c0;
      r.st.p2_held = c1;
    end
    return r;
  endfunction

  function automatic feed_t feed_pass1(filt_st_t s, logic [7:0] nxt);
    feed_t      r;
    filt_st_t   t;
    logic [7:0] c0;
    logic [7:0] p;
    r  = '0;
    t  = s;
    c0 = s.p1_held;
    p  = CH_SPACE;
    if (!s.p1_full) begin
      t.p1_held = nxt;
      t.p1_full = 1'b1;
      r.st      = t;
    end else begin
      if (c0 == CH_SLASH && nxt == CH_SLASH) begin
        t.in_line = 1'b1;
      end else if (c0 == CH_NEWLINE) begin
        t.in_line = 1'b0;
      end
      if (!t.in_line && c0 >= PRINT_LO && c0 <= PRINT_HI) begin
        p = c0;
      end
      r            = feed_pass2(t, p);
      r.st.p1_held = nxt;
    end
    return r;
  endfunction

endpackage

@@ sv/csws_in_if.sv @@
interface csws_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       last_byte;

  modport source (output valid, output text_byte, output last_byte, input ready);
  modport sink   (input valid, input text_byte, input last_byte, output ready);
endinterface

@@ sv/csws_out_if.sv @@
interface csws_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       end_of_text;

  modport source (output valid, output out_byte, output has_byte, output end_of_text,
                  input ready);
  modport sink   (input valid, input out_byte, input has_byte, input end_of_text,
                  output ready);
endinterface

@@ sv/csws_core.sv @@
module csws_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        text_byte_i,
  input  logic              last_byte_i,
  input  logic              load_ok_i,
  output csws_pkg::batch_t  batch_o
);
  import csws_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;
  filt_st_t   st_q, st_d;
  logic       fire;

  feed_t f0, f1, f2, f3;
  logic [MAX_RES-1:0]      keep;
  logic [MAX_RES-1:0][7:0] chs;

  assign fire       = in_valid_q && load_ok_i;
  assign in_ready_o = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_byte_q <= text_byte_i;
      in_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // on the last word: space sentinel, then a zero past the end through both passes
  always_comb begin
    f0 = feed_pass1(st_q, in_byte_q);
    f1 = feed_pass1(f0.st, CH_SPACE);
    f2 = feed_pass1(f1.st, CH_NUL);
    f3 = feed_pass2(f2.st, CH_NUL);
    st_d = in_last_q ? '0 : f0.st;
    keep = {f3.keep, f2.keep, f1.keep, f0.keep} &
           (in_last_q ? {MAX_RES{1'b1}} : MAX_RES'(1));
    chs  = {f3.ch, f2.ch, f1.ch, f0.ch};
  end

  always_comb begin
    logic [CNT_W-1:0] n;
    n = '0;
    batch_o = '0;
    for (int i = 0; i < MAX_RES; i++) begin
      if (keep[i]) begin
        batch_o.bytes[n[IDX_W-1:0]] = chs[i];
        n = n + CNT_W'(1);
      end
    end
    batch_o.load = fire;
    batch_o.eot  = in_last_q;
    // end of text with nothing kept still sends one empty word
    batch_o.has  = !(in_last_q && n == '0);
    batch_o.cnt  = (in_last_q && n == '0) ? CNT_W'(1) : n;
  end

endmodule

@@ sv/csws_obuf.sv @@
module csws_obuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  csws_pkg::batch_t  batch_i,
  output logic              load_ok_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic              has_byte_o,
  output logic              end_of_text_o
);
  import csws_pkg::*;

  logic [MAX_RES-1:0][7:0] ent_q;
  logic [CNT_W-1:0]        rem_q;
  logic [IDX_W-1:0]        idx_q;
  logic                    has_q;
  logic                    eot_q;
  logic                    take;

  assign out_valid_o   = rem_q != '0;
  assign take          = out_valid_o && out_ready_i;
  assign load_ok_o     = (rem_q == '0) || (rem_q == CNT_W'(1) && out_ready_i);
  assign out_byte_o    = ent_q[idx_q];
  assign has_byte_o    = has_q;
  assign end_of_text_o = eot_q && rem_q == CNT_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      idx_q <= '0;
      has_q <= 1'b0;
      eot_q <= 1'b0;
    end else if (batch_i.load) begin
      rem_q <= batch_i.cnt;
      idx_q <= '0;
      has_q <= batch_i.has;
      eot_q <= batch_i.eot;
    end else if (take) begin
      rem_q <= rem_q - CNT_W'(1);
      idx_q <= idx_q + IDX_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (batch_i.load) begin
      ent_q <= batch_i.bytes;
    end
  end

endmodule

@@ sv/comment_strip_whitespace_squeeze.sv @@
// Flow: an accepted word is held in the input register and filtered from it; its results
//   load into the result buffer once that can take them, and are shown from there.
// Throughput: one input word per cycle unless the result buffer stalls; each word yields
//   at most one result word, the last byte up to four, drained one per cycle when ready.
// Reset (rst_ni low, asynchronous): both filter passes, the input and result
//   registers empty; a new text starts after reset and after every end of text.
module comment_strip_whitespace_squeeze (
  input  logic       clk_i,
  input  logic       rst_ni,
  csws_in_if.sink    in_i,
  csws_out_if.source out_o
);
  import csws_pkg::*;

  batch_t batch;
  logic   load_ok;

  csws_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .text_byte_i (in_i.text_byte),
    .last_byte_i (in_i.last_byte),
    .load_ok_i   (load_ok),
    .batch_o     (batch)
  );

  csws_obuf u_obuf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .batch_i       (batch),
    .load_ok_o     (load_ok),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .out_byte_o    (out_o.out_byte),
    .has_byte_o    (out_o.has_byte),
    .end_of_text_o (out_o.end_of_text)
  );

endmodule

@@ sv/csws_chk.sv @@
module csws_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] out_byte_i,
  input logic       has_byte_i,
  input logic       end_of_text_i
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_byte_i) &&
    $stable(has_byte_i) && $stable(end_of_text_i))
    else $error("result word changed while stalled");

  // kept bytes are always printable after the filter
  a_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && has_byte_i |-> out_byte_i >= 8'd32 && out_byte_i <= 8'd127)
    else $error("kept byte outside printable range");

  // a word without a byte is only the empty end marker
  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !has_byte_i |-> end_of_text_i && out_byte_i == 8'd0)
    else $error("empty result word that is not the end marker");

endmodule

bind comment_strip_whitespace_squeeze csws_chk u_csws_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_byte_i    (out_o.out_byte),
  .has_byte_i    (out_o.has_byte),
  .end_of_text_i (out_o.end_of_text)
);
